[rtl/srl_pkg.sv]
// Shared constants, widths and helper functions of the sliding window rate limiter.
package srl_pkg;

	localparam int NUM_ACTIONS = 16;
	localparam int LOG_DEPTH   = 64;

	localparam int TS_W     = 32;
	localparam int REQ_W    = 2;
	localparam int ID_W     = 4;
	localparam int LIMIT_W  = 8;
	localparam int LIVE_W   = 7;
	localparam int SLOT_W   = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1;
	localparam int POS_W    = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
	localparam int CNT_W    = $clog2(LOG_DEPTH + 1);
	localparam int ADDR_W   = (NUM_ACTIONS * LOG_DEPTH > 1) ?
		$clog2(NUM_ACTIONS * LOG_DEPTH) : 1;

	localparam logic [TS_W-1:0] WINDOW_RESET = TS_W'(60000);

	localparam logic [REQ_W-1:0] REQ_ACQUIRE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_QUERY   = 2'd2;

	typedef logic [TS_W-1:0]   stamp_t;
	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [ADDR_W-1:0] addr_t;

	function automatic pos_t next_pos(input pos_t p);
		next_pos = (32'(p) == LOG_DEPTH - 1) ? pos_t'(0) : pos_t'(32'(p) + 1);
	endfunction

	function automatic pos_t tail_pos(input pos_t head, input cnt_t cnt);
		logic [31:0] sum;
		sum = 32'(head) + 32'(cnt);
		tail_pos = (sum >= LOG_DEPTH) ? pos_t'(sum - LOG_DEPTH) : pos_t'(sum);
	endfunction

	function automatic addr_t stamp_addr(input slot_t slot, input pos_t pos);
		stamp_addr = addr_t'(32'(slot) * LOG_DEPTH + 32'(pos));
	endfunction

endpackage

[rtl/sliding_window_rate_limiter.sv]
// Sliding window log rate limiter: top level with sequencer, slot tables and output register.
//
// One request is taken at a time; in_stall stays high from the transfer until the result
// has been loaded into the output register, which may still be waiting on out_stall when
// the next request is taken. A clear request, an unlimited acquire, an unused request
// code or an out-of-range slot goes from the dispatch step to the finish step, where the
// result is loaded and out_valid raised once the output register is free. An acquire or
// count query drops expired entries from the head of the log; each log entry inspected
// costs one read of the stamp memory (registered data) and one pass through the single
// age comparator. The stamp memory needs no clearing pass after reset: only entries
// below the fill count of a slot are ever read. The window register is written by
// cfg_wr_en / cfg_wr_data and must only be written while the block is idle.
module sliding_window_rate_limiter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [srl_pkg::TS_W-1:0]     cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [srl_pkg::REQ_W-1:0]    req_type,
	input  logic [srl_pkg::ID_W-1:0]     action_id,
	input  logic [srl_pkg::LIMIT_W-1:0]  call_limit,
	input  logic [srl_pkg::TS_W-1:0]     timestamp,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         granted,
	output logic [srl_pkg::LIVE_W-1:0]   live_count
);

	import srl_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_FETCH,
		ST_CHECK,
		ST_DECIDE,
		ST_FINISH
	} state_t;

	state_t            state_q;
	stamp_t            window_q;
	logic [REQ_W-1:0]  req_q;
	slot_t             slot_q;
	logic              in_range_q;
	cnt_t              limit_q;
	stamp_t            now_q;
	logic              grant_q;
	pos_t              head_q [NUM_ACTIONS];
	cnt_t              count_q [NUM_ACTIONS];
	logic              out_valid_q;
	logic              granted_q;
	logic [LIVE_W-1:0] live_count_q;

	logic   take;
	logic   out_free;
	logic   ram_we;
	logic   ram_re;
	addr_t  ram_waddr;
	addr_t  ram_raddr;
	stamp_t ram_rdata;
	logic   expired;
	cnt_t   cur_cnt;
	pos_t   cur_head;
	logic   room;

	assign in_stall = (state_q != ST_IDLE);
	assign take     = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign cur_cnt  = count_q[slot_q];
	assign cur_head = head_q[slot_q];
	assign room     = (req_q == REQ_ACQUIRE) && (cur_cnt < limit_q);

	assign ram_re    = (state_q == ST_FETCH);
	assign ram_raddr = stamp_addr(slot_q, cur_head);
	assign ram_we    = (state_q == ST_DECIDE) && room;
	assign ram_waddr = stamp_addr(slot_q, tail_pos(cur_head, cur_cnt));

	srl_stamp_ram #(
		.ADDR_W (ADDR_W),
		.DATA_W (TS_W),
		.DEPTH  (NUM_ACTIONS * LOG_DEPTH)
	) u_stamp_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (now_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	srl_age_unit u_age_unit (
		.now     (now_q),
		.stamp   (ram_rdata),
		.window  (window_q),
		.expired (expired)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (cfg_wr_en) begin
			window_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			grant_q      <= 1'b0;
			req_q        <= REQ_ACQUIRE;
			slot_q       <= '0;
			in_range_q   <= 1'b0;
			limit_q      <= '0;
			now_q        <= '0;
			granted_q    <= 1'b0;
			live_count_q <= '0;
			for (int i = 0; i < NUM_ACTIONS; i++) begin
				head_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else begin
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						req_q      <= req_type;
						slot_q     <= slot_t'(action_id);
						in_range_q <= (32'(action_id) < NUM_ACTIONS);
						limit_q    <= (32'(call_limit) > LOG_DEPTH) ?
							cnt_t'(LOG_DEPTH) : cnt_t'(call_limit);
						now_q      <= timestamp;
						grant_q    <= 1'b0;
						state_q    <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					if (!in_range_q) begin
						state_q <= ST_FINISH;
					end else if (req_q == REQ_CLEAR) begin
						head_q[slot_q]  <= '0;
						count_q[slot_q] <= '0;
						state_q         <= ST_FINISH;
					end else if (req_q == REQ_ACQUIRE && limit_q == '0) begin
						grant_q <= 1'b1;
						state_q <= ST_FINISH;
					end else if (req_q == REQ_ACQUIRE || req_q == REQ_QUERY) begin
						state_q <= (cur_cnt == '0) ? ST_DECIDE : ST_FETCH;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (expired) begin
						head_q[slot_q]  <= next_pos(cur_head);
						count_q[slot_q] <= cur_cnt - cnt_t'(1);
						state_q         <= (cur_cnt == cnt_t'(1)) ? ST_DECIDE : ST_FETCH;
					end else begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (room) begin
						count_q[slot_q] <= cur_cnt + cnt_t'(1);
						grant_q         <= 1'b1;
					end
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						granted_q    <= grant_q;
						live_count_q <= in_range_q ? LIVE_W'(32'(cur_cnt)) : '0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign granted    = granted_q;
	assign live_count = live_count_q;

`ifndef SYNTHESIS
	a_rose_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result appeared outside the finish step");

	a_check_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> (cur_cnt != '0))
		else $error("age check on an empty log");

	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (32'(cur_cnt) < LOG_DEPTH))
		else $error("stamp write into a full log");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(in_range_q && state_q != ST_IDLE) |-> (32'(cur_cnt) <= LOG_DEPTH))
		else $error("log count above depth");

	a_fetch_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH) |=> (state_q == ST_CHECK))
		else $error("stamp read not followed by age check");
`endif

endmodule

[rtl/srl_stamp_ram.sv]
// Single-port-write, single-port-read stamp memory with registered read data.
module srl_stamp_ram #(
	parameter int ADDR_W = 10,
	parameter int DATA_W = 32,
	parameter int DEPTH  = 1024
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/srl_age_unit.sv]
// Shared age comparator: flags a logged stamp older than the window.
module srl_age_unit (
	input  srl_pkg::stamp_t now,
	input  srl_pkg::stamp_t stamp,
	input  srl_pkg::stamp_t window,
	output logic            expired
);

	import srl_pkg::*;

	stamp_t age;

	assign age     = now - stamp;
	assign expired = (age > window);

endmodule

[verif/testbench.sv]
// Self-checking testbench for the sliding window rate limiter, with its own decision predictor.
`timescale 1ns / 1ps

module testbench;
	import srl_pkg::*;

	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 2 * LOG_DEPTH + 16;
	localparam int PHASE_ITEMS = 65;
	localparam int FILL_ITEMS = LOG_DEPTH + 2;
	localparam int NUM_PHASES = 6;
	localparam int RING_SLOTS = 16;

	typedef struct packed {
		logic [REQ_W-1:0]   kind;
		logic [ID_W-1:0]    action;
		logic [LIMIT_W-1:0] limit;
		stamp_t             stamp;
	} request_t;

	typedef struct packed {
		logic              granted;
		logic [LIVE_W-1:0] count;
	} verdict_t;

	typedef struct packed {
		request_t rq;
		logic     typed;
		verdict_t v;
	} row_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [TS_W-1:0]    cfg_wr_data;
	logic               in_valid;
	logic               in_stall;
	logic [REQ_W-1:0]   req_type;
	logic [ID_W-1:0]    action_id;
	logic [LIMIT_W-1:0] call_limit;
	logic [TS_W-1:0]    timestamp;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               granted;
	logic [LIVE_W-1:0]  live_count;

	stamp_t      stamp_mem [NUM_ACTIONS][LOG_DEPTH];
	int unsigned head_of [NUM_ACTIONS];
	int unsigned fill_of [NUM_ACTIONS];
	stamp_t      window_now;
	stamp_t      clock_now;

	verdict_t verdict_ring [RING_SLOTS];
	int       verdicts_queued = 0;
	int       verdicts_retired = 0;
	int       mismatches = 0;
	int       requests_sent = 0;
	int       results_checked = 0;
	int       grants = 0;
	int       refusals = 0;
	int       expired_total = 0;
	int       cycle_count = 0;
	bit       idle_on = 1'b1;
	int       stall_left = 0;

	stamp_t window_plan [NUM_PHASES] = '{32'd100, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'd60000,
		32'd5000};

	row_t script [0:22] = '{
		'{'{REQ_QUERY,   4'd0,  8'd0,   32'd0},          1'b1, '{1'b0, 7'd0}},
		'{'{REQ_ACQUIRE, 4'd0,  8'd1,   32'd0},          1'b1, '{1'b1, 7'd1}},
		'{'{REQ_ACQUIRE, 4'd0,  8'd1,   32'd10},         1'b1, '{1'b0, 7'd1}},
		'{'{REQ_ACQUIRE, 4'd0,  8'd0,   32'd20},         1'b1, '{1'b1, 7'd1}},
		'{'{REQ_UNUSED,  4'd0,  8'd0,   32'd20},         1'b1, '{1'b0, 7'd1}},
		'{'{REQ_QUERY,   4'd0,  8'd0,   32'd60000},      1'b1, '{1'b0, 7'd1}},
		'{'{REQ_QUERY,   4'd0,  8'd0,   32'd60001},      1'b1, '{1'b0, 7'd0}},
		'{'{REQ_ACQUIRE, 4'd15, 8'd255, 32'd60001},      1'b1, '{1'b1, 7'd1}},
		'{'{REQ_ACQUIRE, 4'd15, 8'd65,  32'd60002},      1'b1, '{1'b1, 7'd2}},
		'{'{REQ_ACQUIRE, 4'd15, 8'd64,  32'd60003},      1'b0, '{1'b0, 7'd0}},
		'{'{REQ_CLEAR,   4'd15, 8'd0,   32'd60004},      1'b1, '{1'b0, 7'd0}},
		'{'{REQ_ACQUIRE, 4'd3,  8'd2,   32'hFFFF_FFFF},  1'b1, '{1'b1, 7'd1}},
		'{'{REQ_ACQUIRE, 4'd3,  8'd2,   32'd5},          1'b1, '{1'b1, 7'd2}},
		'{'{REQ_ACQUIRE, 4'd3,  8'd2,   32'd6},          1'b1, '{1'b0, 7'd2}},
		'{'{REQ_QUERY,   4'd3,  8'd0,   32'd60000},      1'b1, '{1'b0, 7'd1}},
		'{'{REQ_ACQUIRE, 4'd3,  8'd2,   32'd60000},      1'b0, '{1'b0, 7'd0}},
		'{'{REQ_CLEAR,   4'd3,  8'd0,   32'd60000},      1'b1, '{1'b0, 7'd0}},
		'{'{REQ_QUERY,   4'd3,  8'd0,   32'd0},          1'b1, '{1'b0, 7'd0}},
		'{'{REQ_ACQUIRE, 4'd7,  8'd128, 32'h8000_0000},  1'b0, '{1'b0, 7'd0}},
		'{'{REQ_ACQUIRE, 4'd7,  8'd1,   32'h8000_0000},  1'b0, '{1'b0, 7'd0}},
		'{'{REQ_QUERY,   4'd7,  8'd0,   32'h8000_EA61},  1'b0, '{1'b0, 7'd0}},
		'{'{REQ_UNUSED,  4'd12, 8'd255, 32'hFFFF_FFFF},  1'b0, '{1'b0, 7'd0}},
		'{'{REQ_CLEAR,   4'd9,  8'd255, 32'd0},          1'b1, '{1'b0, 7'd0}}
	};

	sliding_window_rate_limiter i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.action_id   (action_id),
		.call_limit  (call_limit),
		.timestamp   (timestamp),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.granted     (granted),
		.live_count  (live_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
				verdicts_queued - verdicts_retired);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic void drop_expired(int slot, stamp_t now);
		stamp_t age;
		while (fill_of[slot] > 0) begin
			age = now - stamp_mem[slot][head_of[slot]];
			if (age <= window_now)
				break;
			head_of[slot] = (head_of[slot] + 1) % LOG_DEPTH;
			fill_of[slot] = fill_of[slot] - 1;
			expired_total++;
		end
	endfunction

	function automatic verdict_t decide_request(request_t rq);
		verdict_t    v;
		int          slot;
		int unsigned lim;
		int unsigned pos;
		v = '0;
		slot = int'(rq.action);
		lim = rq.limit;
		case (rq.kind)
			REQ_ACQUIRE: begin
				if (lim == 0) begin
					v.granted = 1'b1;
				end else begin
					if (lim > LOG_DEPTH)
						lim = LOG_DEPTH;
					drop_expired(slot, rq.stamp);
					if (fill_of[slot] < lim) begin
						pos = (head_of[slot] + fill_of[slot]) % LOG_DEPTH;
						stamp_mem[slot][pos] = rq.stamp;
						fill_of[slot] = fill_of[slot] + 1;
						v.granted = 1'b1;
					end
				end
				if (v.granted)
					grants++;
				else
					refusals++;
			end
			REQ_CLEAR: begin
				fill_of[slot] = 0;
				head_of[slot] = 0;
			end
			REQ_QUERY: drop_expired(slot, rq.stamp);
			default: ;
		endcase
		v.count = LIVE_W'(fill_of[slot]);
		return v;
	endfunction

	function automatic int unsigned time_step();
		if (window_now < 8)
			return $urandom_range(0, 2);
		if (window_now == '1)
			return $urandom;
		return $urandom_range(0, window_now / 6);
	endfunction

	function automatic request_t random_request();
		request_t    rq;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		rq.limit = '0;
		if (pick < 72) begin
			rq.kind = REQ_ACQUIRE;
			case ($urandom_range(0, 9))
				0: rq.limit = '0;
				8: rq.limit = LIMIT_W'($urandom_range(9, LOG_DEPTH - 1));
				9: rq.limit = LIMIT_W'($urandom_range(LOG_DEPTH, 255));
				default: rq.limit = LIMIT_W'($urandom_range(1, 8));
			endcase
		end else if (pick < 86) begin
			rq.kind = REQ_QUERY;
		end else if (pick < 95) begin
			rq.kind = REQ_CLEAR;
		end else begin
			rq.kind = REQ_UNUSED;
			rq.limit = LIMIT_W'($urandom);
		end
		if ($urandom_range(0, 4) != 0)
			rq.action = ID_W'($urandom_range(0, 3));
		else
			rq.action = ID_W'($urandom_range(0, NUM_ACTIONS - 1));
		clock_now = clock_now + time_step();
		rq.stamp = clock_now;
		return rq;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("Mismatch at cycle %0d: %s got %0d, expected %0d", cycle_count, what, got,
			want);
		mismatches++;
	endtask

	task automatic drive_request(request_t rq, logic typed, verdict_t typed_v);
		int       gap;
		verdict_t v;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		@(negedge clk);
		in_valid   <= 1'b1;
		req_type   <= rq.kind;
		action_id  <= rq.action;
		call_limit <= rq.limit;
		timestamp  <= rq.stamp;
		do
			@(posedge clk);
		while (in_stall);
		v = decide_request(rq);
		verdict_ring[verdicts_queued % RING_SLOTS] = typed ? typed_v : v;
		verdicts_queued++;
		requests_sent++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (verdicts_queued != verdicts_retired)
			@(posedge clk);
	endtask

	task automatic set_window(stamp_t value);
		drain_results();
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		window_now = value;
	endtask

	task automatic run_phase(bit with_fill);
		request_t rq;
		if (with_fill) begin
			rq.kind = REQ_ACQUIRE;
			rq.action = ID_W'($urandom_range(0, NUM_ACTIONS - 1));
			rq.limit = LIMIT_W'($urandom_range(LOG_DEPTH, 255));
			for (int k = 0; k < FILL_ITEMS; k++) begin
				clock_now = clock_now + $urandom_range(0, 1);
				rq.stamp = clock_now;
				drive_request(rq, 1'b0, '0);
			end
		end
		for (int k = 0; k < PHASE_ITEMS; k++)
			drive_request(random_request(), 1'b0, '0);
	endtask

	always @(negedge clk) begin
		if (!idle_on) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 4) == 0) begin
			out_stall  <= 1'b1;
			stall_left <= $urandom_range(0, 2);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (verdicts_queued == verdicts_retired) begin
				report_mismatch("unexpected result, pending count", 0, 1);
			end else begin
				want = verdict_ring[verdicts_retired % RING_SLOTS];
				verdicts_retired++;
				results_checked++;
				if (granted !== want.granted)
					report_mismatch("granted", int'(granted), int'(want.granted));
				if (live_count !== want.count)
					report_mismatch("live_count", int'(live_count), int'(want.count));
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		req_type    = REQ_ACQUIRE;
		action_id   = '0;
		call_limit  = '0;
		timestamp   = '0;
		window_now  = WINDOW_RESET;
		foreach (fill_of[s]) begin
			fill_of[s] = 0;
			head_of[s] = 0;
		end
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i])
			drive_request(script[i].rq, script[i].typed, script[i].v);

		clock_now = $urandom;
		for (int p = 0; p < NUM_PHASES; p++) begin
			set_window(window_plan[p]);
			if (p == NUM_PHASES - 1)
				idle_on = 1'b0;
			run_phase(window_plan[p] == '1 || window_plan[p] == WINDOW_RESET);
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (verdicts_queued != verdicts_retired)
			report_mismatch("results left outstanding", 0,
				verdicts_queued - verdicts_retired);

		$display("Run covered %0d requests over %0d window settings, %0d results checked",
			requests_sent, NUM_PHASES + 1, results_checked);
		$display("Acquires granted %0d, refused %0d; %0d log entries aged out", grants,
			refusals, expired_total);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
